// File: rtl/core/bfa_pkg.sv
// shared constants and types for the binary32 adder
package bfa_pkg;
  localparam int unsigned WordW  = 32;
  localparam int unsigned ExpW   = 8;
  localparam int unsigned FracW  = 23;
  localparam int unsigned MantW  = 27;  // hidden bit, fraction, guard, round, sticky
  localparam int unsigned ShiftW = 5;
  localparam int unsigned Stages = 4;

  localparam logic [WordW-1:0] InfBits    = 32'h7F80_0000;
  localparam logic [WordW-1:0] DefaultNan = 32'h7FC0_0000;
  localparam logic [WordW-1:0] QuietBit   = 32'h0040_0000;
  localparam logic [ExpW-1:0]  ExpMax     = 8'd255;

  // operands after unpacking and ordering
  typedef struct packed {
    logic             special;
    logic [WordW-1:0] special_word;
    logic             sign;
    logic             sub;
    logic             both_neg;
    logic [ExpW-1:0]  exp;
    logic [MantW-1:0] mant_a;
    logic [MantW-1:0] mant_b;
  } align_t;

  // sum before normalisation
  typedef struct packed {
    logic             special;
    logic [WordW-1:0] special_word;
    logic             sign;
    logic             both_neg;
    logic [ExpW:0]    exp;
    logic [MantW:0]   mant;
  } sum_t;

  // normalised value ready to round
  typedef struct packed {
    logic             special;
    logic [WordW-1:0] special_word;
    logic             sign;
    logic [ExpW:0]    exp;
    logic [MantW-1:0] mant;
  } norm_t;
endpackage

// File: rtl/core/bfa_unpack.sv
// stage one: special cases, magnitude ordering and alignment
module bfa_unpack (
  input  logic [bfa_pkg::WordW-1:0] operand_a_i,
  input  logic [bfa_pkg::WordW-1:0] operand_b_i,
  output bfa_pkg::align_t           align_o
);
  logic [bfa_pkg::WordW-1:0] a, b, big, lit;
  logic a_nan, b_nan, a_inf, b_inf;
  logic [bfa_pkg::ExpW-1:0] eb, el, d;
  logic [bfa_pkg::MantW-1:0] mb, ml, shifted, lost_mask;

  always_comb begin
    a = operand_a_i;
    b = operand_b_i;
    a_nan = a[30:0] > bfa_pkg::InfBits[30:0];
    b_nan = b[30:0] > bfa_pkg::InfBits[30:0];
    a_inf = a[30:0] == bfa_pkg::InfBits[30:0];
    b_inf = b[30:0] == bfa_pkg::InfBits[30:0];
    align_o.special = a_nan | b_nan | a_inf | b_inf;
    if (a_nan) begin
      align_o.special_word = a | bfa_pkg::QuietBit;
    end else if (b_nan) begin
      align_o.special_word = b | bfa_pkg::QuietBit;
    end else if (a_inf && b_inf && (a[31] != b[31])) begin
      align_o.special_word = bfa_pkg::DefaultNan;
    end else if (a_inf) begin
      align_o.special_word = a;
    end else begin
      align_o.special_word = b;
    end
    if (a[30:0] < b[30:0]) begin
      big = b;
      lit = a;
    end else begin
      big = a;
      lit = b;
    end
    eb = (big[30:23] == '0) ? 8'd1 : big[30:23];
    el = (lit[30:23] == '0) ? 8'd1 : lit[30:23];
    mb = {(big[30:23] != '0), big[22:0], 3'b000};
    ml = {(lit[30:23] != '0), lit[22:0], 3'b000};
    d = eb - el;
    lost_mask = '0;
    if (d >= 8'd27) begin
      shifted = {26'd0, (ml != '0)};
    end else begin
      lost_mask = ~({bfa_pkg::MantW{1'b1}} << d[bfa_pkg::ShiftW-1:0]);
      shifted = (ml >> d[bfa_pkg::ShiftW-1:0]);
      shifted[0] = shifted[0] | ((ml & lost_mask) != '0);
    end
    align_o.sign = big[31];
    align_o.sub = big[31] ^ lit[31];
    align_o.both_neg = big[31] & lit[31];
    align_o.exp = eb;
    align_o.mant_a = mb;
    align_o.mant_b = shifted;
  end
endmodule

// File: rtl/core/bfa_norm.sv
// stage three: leading zero count and normalising shift
module bfa_norm (
  input  bfa_pkg::sum_t  sum_i,
  output bfa_pkg::norm_t norm_o
);
  logic [bfa_pkg::ShiftW-1:0] lz, sh;
  logic found;
  logic [bfa_pkg::MantW-1:0] m;

  always_comb begin
    lz = '0;
    sh = '0;
    found = 1'b0;
    m = sum_i.mant[bfa_pkg::MantW-1:0];
    for (int i = bfa_pkg::MantW - 1; i >= 0; i--) begin
      if (!found && m[i]) begin
        found = 1'b1;
        lz = bfa_pkg::ShiftW'(bfa_pkg::MantW - 1 - i);
      end
    end
    if (!found) lz = bfa_pkg::ShiftW'(bfa_pkg::MantW - 1);
    norm_o.special = sum_i.special;
    norm_o.special_word = sum_i.special_word;
    // zero sign: only two negative operands keep it
    norm_o.sign = (sum_i.mant == '0) ? sum_i.both_neg : sum_i.sign;
    if (sum_i.mant[bfa_pkg::MantW]) begin
      norm_o.mant = sum_i.mant[bfa_pkg::MantW:1] | {26'd0, sum_i.mant[0]};
      norm_o.exp = sum_i.exp + 9'd1;
    end else begin
      // shift stops at exponent one so subnormals come out exact
      if ({4'd0, lz} < sum_i.exp) sh = lz;
      else sh = bfa_pkg::ShiftW'(sum_i.exp - 9'd1);
      norm_o.mant = m << sh;
      norm_o.exp = sum_i.exp - {4'd0, sh};
    end
  end
endmodule

// File: rtl/core/binary32_float_adder.sv
// binary32 adder top level, rounds to nearest even
// Adds two IEEE 754 binary32 words with round to nearest even, NaN quieting,
// infinity minus infinity as the default NaN and exact cancellation as +0.
// Four register stages (unpack and align, add, normalise, round and pack);
// one item enters every cycle while the output is taken, and its sum then moves
// through the align, sum, normalise and result registers to the output. Back-pressure stalls the
// whole pipe in place.
module binary32_float_adder (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic [bfa_pkg::WordW-1:0] operand_a_i,
  input  logic [bfa_pkg::WordW-1:0] operand_b_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic [bfa_pkg::WordW-1:0] sum_word_o
);
  logic [bfa_pkg::Stages-1:0] vld_q;
  logic adv;
  bfa_pkg::align_t al_d, al_q;
  bfa_pkg::sum_t   sm_d, sm_q;
  bfa_pkg::norm_t  nm_d, nm_q;
  logic [bfa_pkg::WordW-1:0] res_d, res_q;
  logic [bfa_pkg::FracW+1:0] rm;
  logic [bfa_pkg::ExpW:0] re;
  logic [2:0] g;

  assign adv = out_ready_i | ~vld_q[bfa_pkg::Stages-1];
  assign in_ready_o = adv;
  assign out_valid_o = vld_q[bfa_pkg::Stages-1];
  assign sum_word_o = res_q;

  bfa_unpack u_unpack (.operand_a_i(operand_a_i), .operand_b_i(operand_b_i), .align_o(al_d));

  always_comb begin
    sm_d.special = al_q.special;
    sm_d.special_word = al_q.special_word;
    sm_d.sign = al_q.sign;
    sm_d.both_neg = al_q.both_neg;
    sm_d.exp = {1'b0, al_q.exp};
    sm_d.mant = al_q.sub ? ({1'b0, al_q.mant_a} - {1'b0, al_q.mant_b})
                         : ({1'b0, al_q.mant_a} + {1'b0, al_q.mant_b});
  end

  bfa_norm u_norm (.sum_i(sm_q), .norm_o(nm_d));

  always_comb begin
    g = nm_q.mant[2:0];
    rm = {1'b0, nm_q.mant[bfa_pkg::MantW-1:3]};
    re = nm_q.exp;
    if (g > 3'd4 || (g == 3'd4 && rm[0])) rm = rm + 25'd1;
    if (rm[24]) begin
      rm = rm >> 1;
      re = re + 9'd1;
    end
    if (nm_q.special) begin
      res_d = nm_q.special_word;
    end else if (nm_q.mant == '0) begin
      res_d = {nm_q.sign, 31'd0};
    end else if (re >= {1'b0, bfa_pkg::ExpMax}) begin
      res_d = {nm_q.sign, bfa_pkg::InfBits[30:0]};
    end else if (!rm[23]) begin
      res_d = {nm_q.sign, 8'd0, rm[22:0]};
    end else begin
      res_d = {nm_q.sign, re[7:0], rm[22:0]};
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      al_q <= al_d;
      sm_q <= sm_d;
      nm_q <= nm_d;
      res_q <= res_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[bfa_pkg::Stages-2:0], in_valid_i};
    end
  end
endmodule

// File: rtl/core/bfa_checker.sv
// port-level checks for the binary32 adder
module bfa_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [31:0] sum_word_o
);
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(sum_word_o))
    else $error("stalled sum changed");
  a_ready_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input blocked with empty output");
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && out_ready_i ##1 out_ready_i ##1 out_ready_i
      ##1 out_ready_i |=> out_valid_o)
    else $error("sum missing after four cycles");
  a_follow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i |-> in_ready_o)
    else $error("pipe did not advance");
endmodule

bind binary32_float_adder bfa_checker u_bfa_checker (.*);

// File: tb/binary32_float_adder_tb.sv
// testbench for the binary32 adder: directed table then random operand pairs
module binary32_float_adder_tb;

  localparam int unsigned NumRandom = 800;
  localparam int unsigned CycleLimit = 200000;

  typedef struct {
    logic [31:0] a;
    logic [31:0] b;
    logic        known;
    logic [31:0] sum;
  } vec_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [31:0] operand_a_i = '0;
  logic [31:0] operand_b_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [31:0] sum_word_o;

  logic [31:0] sums_due[$];
  int unsigned n_errors = 0;
  int unsigned cycle_cnt = 0;
  int unsigned hold_cnt = 0;
  logic        sending_done = 1'b0;

  binary32_float_adder u_dut (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .operand_a_i, .operand_b_i,
    .out_valid_o, .out_ready_i, .sum_word_o
  );

  always #1 clk_i = ~clk_i;

  function automatic logic [31:0] fp_add(logic [31:0] a, logic [31:0] b);
    logic [31:0] t, ma, mb, m, lost, g;
    logic        sa, sb;
    int          ea, eb, e, d;
    if (a[30:0] > bfa_pkg::InfBits[30:0]) return a | bfa_pkg::QuietBit;
    if (b[30:0] > bfa_pkg::InfBits[30:0]) return b | bfa_pkg::QuietBit;
    if (a[30:0] == bfa_pkg::InfBits[30:0] && b[30:0] == bfa_pkg::InfBits[30:0] &&
        a[31] != b[31])
      return bfa_pkg::DefaultNan;
    if (a[30:0] == bfa_pkg::InfBits[30:0]) return a;
    if (b[30:0] == bfa_pkg::InfBits[30:0]) return b;
    if (a[30:0] < b[30:0]) begin
      t = a; a = b; b = t;
    end
    sa = a[31];
    sb = b[31];
    ea = a[30:23];
    eb = b[30:23];
    ma = {5'd0, ea != 0, a[22:0], 3'd0};
    mb = {5'd0, eb != 0, b[22:0], 3'd0};
    if (ea == 0) ea = 1;
    if (eb == 0) eb = 1;
    d = ea - eb;
    // smaller operand shifts right, lost bits fold into sticky
    if (d >= 27) begin
      mb = (mb != 0) ? 32'd1 : 32'd0;
    end else begin
      lost = mb & ((32'd1 << d) - 1);
      mb = (mb >> d) | ((lost != 0) ? 32'd1 : 32'd0);
    end
    m = (sa == sb) ? ma + mb : ma - mb;
    e = ea;
    if (m == 0) return (sa && sb) ? 32'h8000_0000 : 32'd0;
    if (m[27]) begin
      m = (m >> 1) | (m & 1);
      e++;
    end else begin
      while (!m[26] && e > 1) begin
        m = m << 1;
        e--;
      end
    end
    g = m & 7;
    m = m >> 3;
    if (g > 4 || (g == 4 && m[0])) m++;
    if (m == 32'h0100_0000) begin
      m = m >> 1;
      e++;
    end
    if (e >= bfa_pkg::ExpMax) return {sa, 31'd0} | bfa_pkg::InfBits;
    if (!m[23]) return {sa, 8'd0, m[22:0]};
    return {sa, e[7:0], m[22:0]};
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %h want %h", what, got, want);
    n_errors++;
  endtask

  function automatic logic [31:0] rand_word();
    logic [31:0] w;
    w = $urandom;
    // bias exponents towards edges so specials and subnormals come often
    case ($urandom_range(0, 7))
      0: w[30:23] = 8'h00;
      1: w[30:23] = 8'hFF;
      2: w[30:23] = 8'($urandom_range(250, 254));
      default: ;
    endcase
    return w;
  endfunction

  // output side: random stalls, a few long ones, and checking
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (sums_due.size() == 0) report_mismatch("unexpected", sum_word_o, 'x);
        else begin
          if (sum_word_o !== sums_due[0]) report_mismatch("sum", sum_word_o, sums_due[0]);
          void'(sums_due.pop_front());
        end
      end
      if (hold_cnt != 0) begin
        out_ready_i <= 1'b0;
        hold_cnt <= hold_cnt - 1;
      end else if (cycle_cnt > 3000 && cycle_cnt % 1000 < 300) begin
        out_ready_i <= 1'b1;
      end else if ($urandom_range(0, 199) == 0) begin
        out_ready_i <= 1'b0;
        hold_cnt <= $urandom_range(10, 40);
      end else begin
        out_ready_i <= ($urandom_range(0, 99) < 5) ? 1'b0 :
                       ($urandom_range(0, 3) != 0);
      end
    end
  end

  task automatic send_item(logic [31:0] a, logic [31:0] b);
    int gap;
    gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) : $urandom_range(0, 2);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    operand_a_i <= a;
    operand_b_i <= b;
    sums_due.push_back(fp_add(a, b));
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
  endtask

  vec_t table_rows[] = '{
    '{32'h0000_0000, 32'h0000_0000, 1'b1, 32'h0000_0000},
    '{32'h8000_0000, 32'h8000_0000, 1'b1, 32'h8000_0000},
    '{32'h8000_0000, 32'h0000_0000, 1'b1, 32'h0000_0000},
    '{32'h3F80_0000, 32'hBF80_0000, 1'b1, 32'h0000_0000},
    '{32'h3F80_0000, 32'h3F80_0000, 1'b1, 32'h4000_0000},
    '{32'h7F80_0000, 32'hFF80_0000, 1'b1, bfa_pkg::DefaultNan},
    '{32'h7F80_0000, 32'h3F80_0000, 1'b1, 32'h7F80_0000},
    '{32'h3F80_0000, 32'hFF80_0000, 1'b1, 32'hFF80_0000},
    '{32'h7F80_0001, 32'h3F80_0000, 1'b1, 32'h7FC0_0001},
    '{32'h3F80_0000, 32'hFF80_0002, 1'b1, 32'hFFC0_0002},
    '{32'h7F80_0001, 32'hFFC0_0000, 1'b1, 32'h7FC0_0001},
    '{32'h7F7F_FFFF, 32'h7F7F_FFFF, 1'b1, 32'h7F80_0000},
    '{32'hFF7F_FFFF, 32'hFF7F_FFFF, 1'b1, 32'hFF80_0000},
    '{32'h0000_0001, 32'h0000_0001, 1'b1, 32'h0000_0002},
    '{32'h007F_FFFF, 32'h0000_0001, 1'b1, 32'h0080_0000},
    '{32'h0000_0001, 32'h8000_0003, 1'b0, 32'h0},
    '{32'h0080_0000, 32'h8000_0001, 1'b0, 32'h0},
    '{32'h3F80_0000, 32'h3380_0000, 1'b0, 32'h0},
    '{32'h3F80_0001, 32'h3380_0000, 1'b0, 32'h0},
    '{32'h3F80_0000, 32'hB3C0_0000, 1'b0, 32'h0},
    '{32'h4B7F_FFFF, 32'h3F00_0000, 1'b0, 32'h0},
    '{32'hFFFF_FFFF, 32'h0000_0000, 1'b1, 32'hFFFF_FFFF},
    '{32'h5555_5555, 32'hAAAA_AAAA, 1'b0, 32'h0},
    '{32'h7F7F_FFFF, 32'h0000_0001, 1'b0, 32'h0}
  };

  initial begin
    logic [31:0] a, b;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (table_rows[i]) begin
      send_item(table_rows[i].a, table_rows[i].b);
      if (table_rows[i].known && sums_due[$] !== table_rows[i].sum)
        report_mismatch("predictor", sums_due[$], table_rows[i].sum);
    end
    for (int n = 0; n < NumRandom; n++) begin
      a = rand_word();
      b = rand_word();
      // close exponents exercise cancellation and renormalisation
      if ($urandom_range(0, 2) == 0) b[30:23] = 8'(a[30:23] + $urandom_range(0, 2) - 1);
      if ($urandom_range(0, 7) == 0) b = a ^ 32'h8000_0000;
      send_item(a, b);
      if (n == NumRandom / 2) begin
        in_valid_i <= 1'b0;
        wait (sums_due.size() == 0);
      end
    end
    in_valid_i <= 1'b0;
    sending_done <= 1'b1;
  end

  initial begin
    wait (sending_done && sums_due.size() == 0);
    repeat (20) @(posedge clk_i);
    if (n_errors == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

  initial begin
    wait (cycle_cnt >= CycleLimit);
    $display("tb: failure");
    $finish;
  end
endmodule
